// ===== rtl/core/wvte_pkg.sv =====
// Package for the waveform vector table encoder
// Holds sequencer state type, status codes and datapath constants; no dependencies
`timescale 1ns / 1ps

package wvte_pkg;

	// divider dividend width: 2 * delta + MIN_STEP_US on a 40-bit delta
	localparam int TIME_W = 40;
	localparam int DIV_W  = 42;
	localparam int WORD_W = 16;

	// step size word of a stop vector
	localparam logic [WORD_W-1:0] STOP_WORD = 16'hFFFF;

	// status codes of a table word
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_ORDER = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV_Q,
		S_DIV_SS,
		S_DIV_NOS,
		S_EMIT
	} wvte_state_t;

endpackage

// ===== rtl/core/waveform_vector_table_encoder_unit.sv =====
// Waveform vector table encoder: first points, stop points and errors give their words
// in the cycle after the request, one word per cycle while out_ready is high; vector and
// stop points seen while the dropping flag is set give none. A vector point runs up to
// three divisions on the shared bit-serial divider before its first word; one request
// is in work at a time. Asynchronous active-low reset clears the previous time, the
// dropping flag and the sequencer; no clearing pass. Uses wvte_pkg and wvte_div.
`timescale 1ns / 1ps

module waveform_vector_table_encoder_unit
	import wvte_pkg::*;
#(
	parameter int MIN_STEP_US   = 5,
	parameter int MAX_STEPS     = 65535,
	parameter int MAX_STEP_SIZE = 32767
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              kind,
	input  logic [TIME_W-1:0] time_us,
	input  logic [WORD_W-1:0] amplitude,
	input  logic [WORD_W-1:0] vector_count,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WORD_W-1:0] word,
	output logic [1:0]        status,
	output logic              last
);

	localparam int LIM_W = 43;
	localparam logic [LIM_W-1:0] LIMIT =
		LIM_W'(longint'(MAX_STEPS) * longint'(MAX_STEP_SIZE) * longint'(MIN_STEP_US));
	localparam logic [WORD_W-1:0] ROUND_DIV = WORD_W'(2 * MIN_STEP_US);
	localparam logic [WORD_W-1:0] STEPS_DIV = WORD_W'(MAX_STEPS);
	localparam logic [DIV_W-1:0]  HALF_STEP = DIV_W'(MIN_STEP_US);
	localparam int Q_W = 32;

	wvte_state_t state_q, state_nx;

	logic [TIME_W-1:0] prev_q;
	logic              drop_q;
	logic [WORD_W-1:0] w_q [3];
	logic [1:0]        st_q;
	logic [1:0]        n_q;
	logic [1:0]        idx_q;
	logic [Q_W-1:0]    q_q;

	logic              in_acc;
	logic              out_acc;
	logic              is_last;
	logic [TIME_W-1:0] delta;
	logic              not_incr;
	logic              too_long;

	logic              div_start;
	logic [DIV_W-1:0]  div_dvd;
	logic [WORD_W-1:0] div_dvs;
	logic              div_done;
	logic [DIV_W-1:0]  div_quo;
	logic [Q_W-1:0]    q_res;

	assign in_acc   = in_valid && in_ready;
	assign out_acc  = out_valid && out_ready;
	assign is_last  = idx_q == (n_q - 2'd1);
	assign delta    = time_us - prev_q;
	assign not_incr = time_us <= prev_q;
	assign too_long = {3'b000, delta} > LIMIT;
	assign q_res    = div_quo[Q_W-1:0];

	// shared divider
	wvte_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (!kind) state_nx = S_EMIT;
					else if (!drop_q) begin
						if (time_us == '0 || not_incr || too_long) state_nx = S_EMIT;
						else state_nx = S_DIV_Q;
					end
				end
			end
			S_DIV_Q: begin
				if (div_done) state_nx = (q_res == '0) ? S_EMIT : S_DIV_SS;
			end
			S_DIV_SS: begin
				if (div_done) state_nx = S_DIV_NOS;
			end
			S_DIV_NOS: begin
				if (div_done) state_nx = S_EMIT;
			end
			S_EMIT: begin
				if (out_acc && is_last) state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// handshake and divider requests
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = ROUND_DIV;
		case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				div_start = in_acc && (state_nx == S_DIV_Q);
				div_dvd   = {1'b0, delta, 1'b0} + HALF_STEP;
				div_dvs   = ROUND_DIV;
			end
			S_DIV_Q: begin
				div_start = div_done && (q_res != '0);
				div_dvd   = DIV_W'(q_res - 1'b1);
				div_dvs   = STEPS_DIV;
			end
			S_DIV_SS: begin
				div_start = div_done;
				div_dvd   = DIV_W'(q_q);
				div_dvs   = div_quo[WORD_W-1:0] + 1'b1;
			end
			S_EMIT: begin
				out_valid = 1'b1;
			end
			default: begin
				out_valid = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			prev_q  <= '0;
			drop_q  <= 1'b0;
			idx_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_IDLE && in_acc) begin
				idx_q <= '0;
				if (!kind) begin
					drop_q <= 1'b0;
					prev_q <= time_us;
				end else if (!drop_q) begin
					if (time_us == '0) prev_q <= '0;
					else if (not_incr || too_long) drop_q <= 1'b1;
					else prev_q <= time_us;
				end
			end else if (state_q == S_EMIT && out_acc) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	// result words
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					st_q   <= ST_OK;
					n_q    <= 2'd3;
					w_q[2] <= amplitude;
					if (!kind) begin
						w_q[0] <= vector_count;
						w_q[1] <= '0;
					end else if (time_us == '0) begin
						w_q[0] <= '0;
						w_q[1] <= STOP_WORD;
					end else if (not_incr) begin
						st_q   <= ST_ORDER;
						n_q    <= 2'd1;
						w_q[0] <= '0;
					end else if (too_long) begin
						st_q   <= ST_RANGE;
						n_q    <= 2'd1;
						w_q[0] <= '0;
					end
				end
			end
			S_DIV_Q: begin
				if (div_done) begin
					q_q    <= q_res;
					w_q[0] <= '0;
					w_q[1] <= 16'd1;
				end
			end
			S_DIV_SS: begin
				if (div_done) begin
					w_q[1] <= div_quo[WORD_W-1:0] + 1'b1;
				end
			end
			S_DIV_NOS: begin
				if (div_done) w_q[0] <= div_quo[WORD_W-1:0];
			end
			default: ;
		endcase
	end

	assign word   = w_q[idx_q];
	assign status = st_q;
	assign last   = is_last;

endmodule

// ===== rtl/core/wvte_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle
// Uses wvte_pkg for widths
`timescale 1ns / 1ps

module wvte_div
	import wvte_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_W-1:0]  dividend,
	input  logic [WORD_W-1:0] divisor,
	output logic              done,
	output logic [DIV_W-1:0]  quotient
);

	localparam int CNT_W = $clog2(DIV_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WORD_W-1:0] rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [WORD_W-1:0] dvs_q;

	logic [WORD_W:0]   trial;
	logic              fits;
	logic [WORD_W-1:0] rem_nx;

	// one trial subtraction on the narrow partial remainder
	always_comb begin
		trial  = {rem_q, quo_q[DIV_W-1]};
		fits   = trial >= {1'b0, dvs_q};
		rem_nx = fits ? WORD_W'(trial - {1'b0, dvs_q}) : trial[WORD_W-1:0];
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend bits shift out, quotient bits shift in; divisor held for the run
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
